FILE: sv/ipid_pkg.sv
`default_nettype none
package ipid_pkg;

  localparam int STEP_W = 4;
  localparam int ACC_W  = 43;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ERR   = 3'd1,
    OP_CLAMP = 3'd2,
    OP_DIFF  = 3'd3,
    OP_LOAD  = 3'd4,
    OP_ACC   = 3'd5,
    OP_FIN   = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_SCALE = 3'd1,
    MUL_KP    = 3'd2,
    MUL_KI    = 3'd3,
    MUL_KD    = 3'd4,
    MUL_KC    = 3'd5
  } mul_sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,
    SEQ_END  = 2'd1
  } seq_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t mul;
    seq_t     seq;
  } ctrl_t;

  typedef enum logic [2:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_KC    = 3'd3,
    REG_SCALE = 3'd4,
    REG_BAND  = 3'd5,
    REG_CLAMP = 3'd6,
    REG_HIGH  = 3'd7
  } reg_idx_t;

  // Microprogram: one control word per step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    begin
      w = '{op: OP_NONE, mul: MUL_NONE, seq: SEQ_END};
      case (step)
        4'd0: w = '{op: OP_ERR,   mul: MUL_NONE,  seq: SEQ_NEXT};
        4'd1: w = '{op: OP_NONE,  mul: MUL_SCALE, seq: SEQ_NEXT};
        4'd2: w = '{op: OP_CLAMP, mul: MUL_NONE,  seq: SEQ_NEXT};
        4'd3: w = '{op: OP_DIFF,  mul: MUL_NONE,  seq: SEQ_NEXT};
        4'd4: w = '{op: OP_LOAD,  mul: MUL_KP,    seq: SEQ_NEXT};
        4'd5: w = '{op: OP_ACC,   mul: MUL_KI,    seq: SEQ_NEXT};
        4'd6: w = '{op: OP_ACC,   mul: MUL_KD,    seq: SEQ_NEXT};
        4'd7: w = '{op: OP_ACC,   mul: MUL_KC,    seq: SEQ_NEXT};
        4'd8: w = '{op: OP_FIN,   mul: MUL_NONE,  seq: SEQ_END};
        default: w = '{op: OP_NONE, mul: MUL_NONE, seq: SEQ_END};
      endcase
      return w;
    end
  endfunction

  function automatic logic signed [31:0] sat_33(input logic signed [32:0] x);
    logic signed [31:0] r;
    begin
      if (x[32] != x[31]) begin
        r = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        r = x[31:0];
      end
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat_40(input logic signed [39:0] x);
    logic signed [31:0] r;
    begin
      if (x > 40'sd2147483647) begin
        r = 32'sh7fff_ffff;
      end else if (x < -40'sd2147483648) begin
        r = 32'sh8000_0000;
      end else begin
        r = x[31:0];
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/ipid_seq.sv
`default_nettype none
module ipid_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          hold,
  output ipid_pkg::ctrl_t    ctrl,
  output logic               busy
);
  import ipid_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;

  assign ctrl = ucode(step);
  assign busy = (state == S_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            step  <= '0;
          end
        end
        S_RUN: begin
          if (ctrl.seq == SEQ_NEXT) begin
            step <= step + 1'b1;
          end else if (!hold) begin
            // end of program: return to idle
            state <= S_IDLE;
            step  <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
          step  <= '0;
        end
      endcase
    end
  end

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (start && state == S_IDLE) |=> (busy && step == '0))
    else $error("sequencer did not start at step zero");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step <= 4'd8))
    else $error("step counter ran past the program");

  a_hold_stays: assert property (@(posedge clk) disable iff (rst)
    (busy && ctrl.seq == SEQ_END && hold) |=> (busy && $stable(step)))
    else $error("final step left while output was held");

endmodule
`default_nettype wire

FILE: sv/incremental_pid_deadband_clamp.sv
// Input is stalled while the program runs, so a new item is accepted only
// after the last one is finished; a nine-step microprogram runs all
// five Q8.24 products through a single shared 32x32 multiplier.
// The last step waits while a previous drive value is still stalled.
// Reset (rst, synchronous): registers take their documented defaults, the
// kept error, error change and output accumulator clear to zero, no result pending.
`default_nettype none
module incremental_pid_deadband_clamp #(
  parameter int                 INVERT_ERROR     = 0,
  parameter logic signed [31:0] OUTPUT_LOW_LIMIT = -32'sd16777216
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input transaction
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] target,
  input  wire logic signed [31:0] measured,
  input  wire logic signed [31:0] current_delta,
  // output transaction
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      drive,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import ipid_pkg::*;

  // Configuration registers
  logic signed [31:0] gain_proportional;
  logic signed [31:0] gain_integral;
  logic signed [31:0] gain_derivative;
  logic signed [31:0] gain_compensation;
  logic signed [31:0] error_scale;
  logic [30:0]        dead_band;
  logic [30:0]        error_clamp;
  logic signed [31:0] output_high;

  // Controller state kept across items
  logic signed [31:0] previous_error;
  logic signed [31:0] previous_change;
  logic signed [31:0] output_accumulator;

  // Captured item and working registers
  logic signed [31:0] tgt;
  logic signed [31:0] meas;
  logic signed [31:0] cdelta;
  logic signed [31:0] mx;       // error after dead band, before scaling
  logic signed [31:0] err;      // scaled and clamped error
  logic signed [31:0] chg;      // error change
  logic signed [31:0] esum;     // present plus last error
  logic signed [31:0] second;   // second difference
  logic signed [63:0] prod;     // shared multiplier output register
  logic signed [ACC_W-1:0] acc;

  ctrl_t ctrl;
  logic  busy;
  logic  accept;
  logic  hold;
  logic  fin_go;

  // Refuse input and configuration transactions while reset is applied.
  assign cfg_ready = !rst;
  assign in_stall  = busy || rst;
  assign accept    = in_valid && !in_stall;
  // Hold the final step while the previous result is still stalled.
  assign hold      = out_valid && out_stall;
  assign fin_go    = busy && (ctrl.op == OP_FIN) && !hold;

  ipid_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .hold  (hold),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_proportional <= '0;
      gain_integral     <= '0;
      gain_derivative   <= '0;
      gain_compensation <= '0;
      error_scale       <= 32'sd16777216;
      dead_band         <= '0;
      error_clamp       <= 31'd3355443;
      output_high       <= 32'sd16777216;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_KP:    gain_proportional <= cfg_data;
        REG_KI:    gain_integral     <= cfg_data;
        REG_KD:    gain_derivative   <= cfg_data;
        REG_KC:    gain_compensation <= cfg_data;
        REG_SCALE: error_scale       <= cfg_data;
        REG_BAND:  dead_band         <= cfg_data[30:0];
        REG_CLAMP: error_clamp       <= cfg_data[30:0];
        REG_HIGH:  output_high       <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Raw error, saturated to 32 bits
  logic signed [32:0] raw_diff;
  logic signed [31:0] raw;
  assign raw_diff = (INVERT_ERROR != 0) ? (33'(meas) - 33'(tgt)) : (33'(tgt) - 33'(meas));
  assign raw      = sat_33(raw_diff);

  // Dead band bypass when 5*target < 6*band, computed exactly with shifts
  logic signed [35:0] tgt5;
  logic signed [35:0] band6;
  logic               bypass;
  logic signed [31:0] band_s;
  logic signed [31:0] db_value;
  assign tgt5   = (36'(tgt) <<< 2) + 36'(tgt);
  assign band6  = (36'({1'b0, dead_band}) <<< 2) + (36'({1'b0, dead_band}) <<< 1);
  assign bypass = tgt5 < band6;
  assign band_s = {1'b0, dead_band};

  always_comb begin
    if (bypass) begin
      db_value = raw;
    end else if (raw >= band_s) begin
      db_value = sat_33(33'(raw) - 33'(band_s));
    end else if (raw <= -band_s) begin
      db_value = sat_33(33'(raw) + 33'(band_s));
    end else begin
      db_value = '0;
    end
  end

  // Floor of product over 2^24 is the upper part of the exact product.
  logic signed [39:0] term;
  logic signed [31:0] scaled;
  logic signed [31:0] clamp_s;
  logic signed [31:0] err_clamped;
  assign term    = prod[63:24];
  assign scaled  = sat_40(term);
  assign clamp_s = {1'b0, error_clamp};

  always_comb begin
    if (scaled > clamp_s) begin
      err_clamped = clamp_s;
    end else if (scaled < -clamp_s) begin
      err_clamped = -clamp_s;
    end else begin
      err_clamped = scaled;
    end
  end

  // Shared multiplier operand select
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  always_comb begin
    case (ctrl.mul)
      MUL_SCALE: begin mul_a = mx;                mul_b = error_scale;       end
      MUL_KP:    begin mul_a = gain_proportional; mul_b = chg;               end
      MUL_KI:    begin mul_a = gain_integral;     mul_b = esum;              end
      MUL_KD:    begin mul_a = gain_derivative;   mul_b = second;            end
      MUL_KC:    begin mul_a = cdelta;            mul_b = gain_compensation; end
      default:   begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  // Final sum and output clamp; upper limit is tested first.
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] hi_ext;
  logic signed [ACC_W-1:0] lo_ext;
  logic signed [31:0]      result;
  assign acc_sum = acc + ACC_W'(term);
  assign hi_ext  = ACC_W'(output_high);
  assign lo_ext  = {{(ACC_W-32){OUTPUT_LOW_LIMIT[31]}}, OUTPUT_LOW_LIMIT};

  always_comb begin
    if (acc_sum > hi_ext) begin
      result = output_high;
    end else if (acc_sum < lo_ext) begin
      result = OUTPUT_LOW_LIMIT;
    end else begin
      result = acc_sum[31:0];
    end
  end

  // Datapath driven by the control word
  always_ff @(posedge clk) begin
    if (accept) begin
      tgt    <= target;
      meas   <= measured;
      cdelta <= current_delta;
    end
    if (busy) begin
      if (ctrl.mul != MUL_NONE) begin
        prod <= mul_a * mul_b;
      end
      case (ctrl.op)
        OP_ERR:   mx  <= db_value;
        OP_CLAMP: err <= err_clamped;
        OP_DIFF: begin
          chg  <= sat_33(33'(err) - 33'(previous_error));
          esum <= sat_33(33'(err) + 33'(previous_error));
        end
        OP_LOAD: begin
          second <= sat_33(33'(chg) - 33'(previous_change));
          acc    <= ACC_W'(output_accumulator);
        end
        OP_ACC:  acc <= acc_sum;
        default: ;
      endcase
    end
  end

  // Kept state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error     <= '0;
      previous_change    <= '0;
      output_accumulator <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (fin_go) begin
        previous_error     <= err;
        previous_change    <= chg;
        output_accumulator <= result;
        drive              <= result;
        out_valid          <= 1'b1;
      end else if (!out_stall) begin
        // drop the result once taken
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not start the program");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (out_valid && drive == $past(result)))
    else $error("final step did not load the output register");

  a_drive_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive <= output_high || drive == OUTPUT_LOW_LIMIT))
    else $error("drive outside output limits");

  a_kept_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (drive == output_accumulator))
    else $error("kept output differs from delivered drive");

endmodule
`default_nettype wire
